// ===== src/tfp_pkg.sv =====
package tfp_pkg;

    // Frame layout constants.
    localparam logic [7:0]  HDR_MARK  = 8'hFA;
    localparam logic [10:0] POS_LIMIT = 11'd2047;
    localparam logic [6:0]  LOAD_MAX  = 7'd100;

    // Frame type codes.
    localparam logic [7:0] T_CPU    = 8'd1;
    localparam logic [7:0] T_TEMP   = 8'd2;
    localparam logic [7:0] T_RAM    = 8'd3;
    localparam logic [7:0] T_DISK   = 8'd4;
    localparam logic [7:0] T_UPTIME = 8'd5;
    localparam logic [7:0] T_STATE  = 8'd6;

    // Result status codes.
    localparam logic [3:0] ST_OK    = 4'd0;
    localparam logic [3:0] ST_PART  = 4'd1;
    localparam logic [3:0] ST_STALE = 4'd2;
    localparam logic [3:0] ST_SHORT = 4'd3;
    localparam logic [3:0] ST_HDR   = 4'd4;
    localparam logic [3:0] ST_LEN   = 4'd5;
    localparam logic [3:0] ST_TRUNC = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_QUERY = 4'd8;

    // One job handed from the front end to the decoder.
    typedef struct packed {
        logic        is_query;
        logic [5:0]  core_index;
        logic [11:0] total;
        logic        header_ok;
        logic [15:0] frame_length;
        logic [7:0]  frame_type;
        logic [7:0]  xor_acc;
    } job_t;

endpackage

// ===== src/tfp_ifs.sv =====
interface tfp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;
    logic       end_of_datagram;
    logic [5:0] core_index;

    modport source (output valid, action, data_byte, end_of_datagram, core_index,
                    input ready);
    modport sink (input valid, action, data_byte, end_of_datagram, core_index,
                  output ready);
endinterface

interface tfp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [6:0]  overall_load;
    logic [6:0]  core_count;
    logic [7:0]  temperature;
    logic [15:0] ram_used_mb;
    logic [15:0] ram_total_mb;
    logic [6:0]  ram_percent;
    logic [53:0] disk_read_kbps;
    logic [53:0] disk_write_kbps;
    logic [31:0] uptime_seconds;
    logic [31:0] newest_sequence;
    logic [6:0]  core_load;

    modport source (output valid, status, overall_load, core_count, temperature,
                    ram_used_mb, ram_total_mb, ram_percent, disk_read_kbps,
                    disk_write_kbps, uptime_seconds, newest_sequence, core_load,
                    input ready);
    modport sink (input valid, status, overall_load, core_count, temperature,
                  ram_used_mb, ram_total_mb, ram_percent, disk_read_kbps,
                  disk_write_kbps, uptime_seconds, newest_sequence, core_load,
                  output ready);
endinterface

// ===== src/tfp_ram.sv =====
module tfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/tfp_fifo.sv =====
module tfp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tfp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output tfp_pkg::job_t head
);
    import tfp_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end
endmodule

// ===== src/tfp_pct_div.sv =====
module tfp_pct_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [22:0] num,
    input  logic [15:0] den,
    output logic        done,
    output logic [6:0]  quot
);
    logic [22:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [6:0]  q_reg, q_next;
    logic [2:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [22:0] den_sh;

    assign den_sh = 23'(den_reg) << step_reg;
    assign done   = done_reg;
    assign quot   = q_reg;

    // Restoring division, one quotient bit per cycle; the quotient fits in 7 bits.
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            q_next    = 7'd0;
            step_next = 3'd6;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= den_sh)
            begin
                rem_next         = rem_reg - den_sh;
                q_next[step_reg] = 1'b1;
            end
            if (step_reg == 3'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
            q_reg    <= 7'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
    end
endmodule

// ===== src/tfp_front.sv =====
module tfp_front #(
    parameter int MAX_PAYLOAD_BYTES = 128,
    localparam int PW = $clog2(MAX_PAYLOAD_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    tfp_in_if.sink        datagram,
    output logic          push,
    output tfp_pkg::job_t push_job,
    input  logic          fifo_full,
    input  logic          frame_done,
    output logic          buf_we,
    output logic [PW-1:0] buf_waddr,
    output logic [7:0]    buf_wdata
);
    import tfp_pkg::*;

    localparam logic [10:0] BUF_DEPTH = 11'(MAX_PAYLOAD_BYTES);

    logic [10:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  type_reg, type_next;
    logic        hdr_reg, hdr_next;
    logic [7:0]  xor_reg, xor_next;
    logic        busy_reg, busy_next;
    logic        accept;
    logic [10:0] idx;
    logic [7:0]  b;

    // A frame under decode owns the payload buffer, so bytes wait until it is done.
    assign datagram.ready = !fifo_full && !busy_reg;
    assign accept         = datagram.valid && datagram.ready;
    assign b              = datagram.data_byte;
    assign idx            = pos_reg - 11'd4;
    assign buf_waddr      = idx[PW-1:0];
    assign buf_wdata      = b;

    // Byte parser: header, length, type, then payload into the buffer.
    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        type_next = type_reg;
        hdr_next  = hdr_reg;
        xor_next  = xor_reg;
        busy_next = busy_reg;
        buf_we    = 1'b0;
        push      = 1'b0;
        if (frame_done)
        begin
            busy_next = 1'b0;
        end
        if (accept && !datagram.action)
        begin
            if (pos_reg == 11'd0)
            begin
                hdr_next = (b == HDR_MARK);
            end
            else if (pos_reg == 11'd1)
            begin
                len_next = {8'd0, b};
                xor_next = xor_reg ^ b;
            end
            else if (pos_reg == 11'd2)
            begin
                len_next = {b, len_reg[7:0]};
                xor_next = xor_reg ^ b;
            end
            else if (pos_reg == 11'd3)
            begin
                type_next = b;
                xor_next  = xor_reg ^ b;
            end
            else if (pos_reg < POS_LIMIT)
            begin
                buf_we = (idx < BUF_DEPTH);
                if ((16'(idx) + 16'd1) < len_reg)
                begin
                    xor_next = xor_reg ^ b;
                end
            end
            if (pos_reg < POS_LIMIT)
            begin
                pos_next = pos_reg + 11'd1;
            end
        end
        push_job.is_query     = datagram.action;
        push_job.core_index   = datagram.core_index;
        push_job.total        = 12'(pos_reg) + 12'd1;
        push_job.header_ok    = hdr_next;
        push_job.frame_length = len_next;
        push_job.frame_type   = type_next;
        push_job.xor_acc      = xor_next;
        if (accept && (datagram.action || datagram.end_of_datagram))
        begin
            push = 1'b1;
        end
        // The final byte hands the frame over and clears the parser.
        if (accept && !datagram.action && datagram.end_of_datagram)
        begin
            busy_next = 1'b1;
            pos_next  = 11'd0;
            len_next  = 16'd0;
            type_next = 8'd0;
            hdr_next  = 1'b0;
            xor_next  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 11'd0;
            len_reg  <= 16'd0;
            type_reg <= 8'd0;
            hdr_reg  <= 1'b0;
            xor_reg  <= 8'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            type_reg <= type_next;
            hdr_reg  <= hdr_next;
            xor_reg  <= xor_next;
            busy_reg <= busy_next;
        end
    end
endmodule

// ===== src/tfp_back.sv =====
module tfp_back #(
    parameter int MAX_PAYLOAD_BYTES = 128,
    parameter int MAX_CORES = 64,
    localparam int PW = $clog2(MAX_PAYLOAD_BYTES),
    localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  tfp_pkg::job_t job,
    output logic          job_pop,
    output logic [PW-1:0] buf_raddr,
    input  logic [7:0]    buf_rdata,
    output logic          frame_done,
    tfp_out_if.source     result
);
    import tfp_pkg::*;

    localparam logic [16:0] LEN_MAX   = 17'(MAX_PAYLOAD_BYTES);
    localparam logic [7:0]  CORES_MAX = 8'(MAX_CORES);

    // Sequencer states.
    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_DISP  = 4'd1;
    localparam logic [3:0] B_QWAIT = 4'd2;
    localparam logic [3:0] B_CHK   = 4'd3;
    localparam logic [3:0] B_SEGST = 4'd4;
    localparam logic [3:0] B_RD    = 4'd5;
    localparam logic [3:0] B_BYTE  = 4'd6;
    localparam logic [3:0] B_ZERO  = 4'd7;
    localparam logic [3:0] B_DIV   = 4'd8;
    localparam logic [3:0] B_OUT   = 4'd9;

    // Payload segments.
    localparam logic [2:0] SG_SEQ   = 3'd0;
    localparam logic [2:0] SG_LC    = 3'd1;
    localparam logic [2:0] SG_CORES = 3'd2;
    localparam logic [2:0] SG_TEMP  = 3'd3;
    localparam logic [2:0] SG_RAM   = 3'd4;
    localparam logic [2:0] SG_DISK  = 3'd5;
    localparam logic [2:0] SG_UP    = 3'd6;
    localparam logic [2:0] SG_DONE  = 3'd7;

    function automatic logic [2:0] first_seg(input logic [7:0] t);
        logic [2:0] s;
        case (t)
            T_STATE:  s = SG_SEQ;
            T_CPU:    s = SG_LC;
            T_TEMP:   s = SG_TEMP;
            T_RAM:    s = SG_RAM;
            T_DISK:   s = SG_DISK;
            T_UPTIME: s = SG_UP;
            default:  s = SG_DONE;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] next_seg(input logic [2:0] s, input logic [7:0] t);
        logic [2:0] n;
        n = SG_DONE;
        if (t == T_STATE)
        begin
            case (s)
                SG_SEQ:   n = SG_LC;
                SG_LC:    n = SG_CORES;
                SG_CORES: n = SG_TEMP;
                SG_TEMP:  n = SG_RAM;
                SG_RAM:   n = SG_DISK;
                SG_DISK:  n = SG_UP;
                default:  n = SG_DONE;
            endcase
        end
        else if (t == T_CPU && s == SG_LC)
        begin
            n = SG_CORES;
        end
        return n;
    endfunction

    function automatic logic [6:0] clamp_load(input logic [7:0] v);
        return (v > 8'(LOAD_MAX)) ? LOAD_MAX : v[6:0];
    endfunction

    logic [3:0]  st_reg, st_next;
    job_t        job_reg, job_next;
    logic [10:0] c_reg, c_next;
    logic [10:0] d_reg, d_next;
    logic [2:0]  seg_reg, seg_next;
    logic [7:0]  k_reg, k_next;
    logic [63:0] acc_reg, acc_next;
    logic [7:0]  ncp_reg, ncp_next;
    logic [53:0] rdp_reg, rdp_next;
    logic [7:0]  zi_reg, zi_next;
    logic        qv_reg, qv_next;
    logic [3:0]  ostat_reg, ostat_next;
    logic [6:0]  ocl_reg, ocl_next;

    logic [31:0] seq_reg, seq_next;
    logic [7:0]  cores_reg, cores_next;
    logic [6:0]  load_reg, load_next;
    logic [7:0]  temp_reg, temp_next;
    logic [15:0] tot_reg, tot_next;
    logic [15:0] used_reg, used_next;
    logic [6:0]  pct_reg, pct_next;
    logic [53:0] drd_reg, drd_next;
    logic [53:0] dwr_reg, dwr_next;
    logic [31:0] up_reg, up_next;
    logic [MAX_CORES-1:0] vld_reg, vld_next;

    logic          core_we;
    logic [CW-1:0] core_waddr;
    logic [6:0]    core_wdata;
    logic [CW-1:0] core_raddr;
    logic [6:0]    core_rdata;
    logic          div_start;
    logic [22:0]   div_num;
    logic          div_done;
    logic [6:0]    div_q;

    logic [7:0]  qidx;
    logic        qin;
    logic [8:0]  seg_len;
    logic [10:0] rem;
    logic [63:0] acc_new;
    logic [7:0]  nc_clamp;
    logic [15:0] ram_tot;
    logic [15:0] ram_used;
    logic [15:0] used_c;

    assign qidx       = {2'b00, job_reg.core_index};
    assign qin        = (qidx < cores_reg);
    assign core_raddr = qidx[CW-1:0];
    assign rem        = d_reg - c_reg;
    assign buf_raddr  = (st_reg == B_DISP) ? PW'(job_reg.frame_length - 16'd1)
                                           : c_reg[PW-1:0];

    // Byte just read, merged into the little-endian field assembler.
    always_comb
    begin
        acc_new = acc_reg;
        acc_new[k_reg[2:0]*8 +: 8] = buf_rdata;
    end

    assign ram_tot  = acc_new[15:0];
    assign ram_used = acc_new[31:16];
    assign used_c   = (ram_used > ram_tot) ? ram_tot : ram_used;
    assign div_num  = 23'(used_c) * 23'd100;

    always_comb
    begin
        if (acc_new[15:8] == 8'd0)
        begin
            nc_clamp = 8'd1;
        end
        else if (acc_new[15:8] > CORES_MAX)
        begin
            nc_clamp = CORES_MAX;
        end
        else
        begin
            nc_clamp = acc_new[15:8];
        end
    end

    // Byte count of the current segment.
    always_comb
    begin
        case (seg_reg)
            SG_SEQ:   seg_len = 9'd4;
            SG_LC:    seg_len = 9'd2;
            SG_CORES: seg_len = (job_reg.frame_type == T_STATE) ? {1'b0, ncp_reg}
                                                                : {1'b0, cores_reg};
            SG_TEMP:  seg_len = 9'd1;
            SG_RAM:   seg_len = 9'd4;
            SG_DISK:  seg_len = 9'd16;
            SG_UP:    seg_len = 9'd4;
            default:  seg_len = 9'd0;
        endcase
    end

    tfp_ram #(.WIDTH(7), .DEPTH(MAX_CORES)) u_core_ram (
        .clk   (clk),
        .we    (core_we),
        .waddr (core_waddr),
        .wdata (core_wdata),
        .raddr (core_raddr),
        .rdata (core_rdata)
    );

    tfp_pct_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (ram_tot),
        .done  (div_done),
        .quot  (div_q)
    );

    // Decode sequencer.
    always_comb
    begin
        st_next    = st_reg;
        job_next   = job_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        seg_next   = seg_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        ncp_next   = ncp_reg;
        rdp_next   = rdp_reg;
        zi_next    = zi_reg;
        qv_next    = qv_reg;
        ostat_next = ostat_reg;
        ocl_next   = ocl_reg;
        seq_next   = seq_reg;
        cores_next = cores_reg;
        load_next  = load_reg;
        temp_next  = temp_reg;
        tot_next   = tot_reg;
        used_next  = used_reg;
        pct_next   = pct_reg;
        drd_next   = drd_reg;
        dwr_next   = dwr_reg;
        up_next    = up_reg;
        vld_next   = vld_reg;
        job_pop    = 1'b0;
        div_start  = 1'b0;
        core_we    = 1'b0;
        core_waddr = k_reg[CW-1:0];
        core_wdata = clamp_load(buf_rdata);
        frame_done = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop  = 1'b1;
                    job_next = job;
                    st_next  = B_DISP;
                end
            end
            B_DISP:
            begin
                ocl_next = 7'd0;
                if (job_reg.is_query)
                begin
                    qv_next = qin && vld_reg[qidx[CW-1:0]];
                    st_next = B_QWAIT;
                end
                else if (job_reg.total < 12'd4)
                begin
                    ostat_next = ST_SHORT;
                    st_next    = B_OUT;
                end
                else if (!job_reg.header_ok)
                begin
                    ostat_next = ST_HDR;
                    st_next    = B_OUT;
                end
                else if (job_reg.frame_length == 16'd0
                         || 17'(job_reg.frame_length) > LEN_MAX)
                begin
                    ostat_next = ST_LEN;
                    st_next    = B_OUT;
                end
                else if ((17'(job_reg.frame_length) + 17'd4) > 17'(job_reg.total))
                begin
                    ostat_next = ST_TRUNC;
                    st_next    = B_OUT;
                end
                else
                begin
                    st_next = B_CHK;
                end
            end
            B_QWAIT:
            begin
                ostat_next = ST_QUERY;
                ocl_next   = qin ? (qv_reg ? core_rdata : LOAD_MAX) : 7'd0;
                st_next    = B_OUT;
            end
            B_CHK:
            begin
                if (buf_rdata != job_reg.xor_acc)
                begin
                    ostat_next = ST_CHK;
                    st_next    = B_OUT;
                end
                else
                begin
                    c_next   = 11'd0;
                    d_next   = 11'(job_reg.frame_length - 16'd1);
                    seg_next = first_seg(job_reg.frame_type);
                    st_next  = B_SEGST;
                end
            end
            B_SEGST:
            begin
                k_next = 8'd0;
                if (seg_reg == SG_DONE)
                begin
                    ostat_next = ST_OK;
                    st_next    = B_OUT;
                end
                else if (rem < 11'(seg_len))
                begin
                    ostat_next = ST_PART;
                    st_next    = B_OUT;
                end
                else
                begin
                    if (seg_reg == SG_CORES && job_reg.frame_type == T_STATE)
                    begin
                        cores_next = ncp_reg;
                    end
                    st_next = B_RD;
                end
            end
            B_RD:
            begin
                st_next = B_BYTE;
            end
            B_BYTE:
            begin
                acc_next = acc_new;
                c_next   = c_reg + 11'd1;
                k_next   = k_reg + 8'd1;
                st_next  = B_RD;
                if (seg_reg == SG_CORES)
                begin
                    core_we                 = 1'b1;
                    vld_next[k_reg[CW-1:0]] = 1'b1;
                end
                if (seg_reg == SG_DISK && k_reg == 8'd7)
                begin
                    rdp_next = acc_new[63:10];
                end
                // Last byte of the segment: commit its fields.
                if ((9'(k_reg) + 9'd1) == seg_len)
                begin
                    st_next  = B_SEGST;
                    seg_next = next_seg(seg_reg, job_reg.frame_type);
                    case (seg_reg)
                        SG_SEQ:
                        begin
                            if (acc_new[31:0] <= seq_reg)
                            begin
                                ostat_next = ST_STALE;
                                st_next    = B_OUT;
                            end
                            else
                            begin
                                seq_next = acc_new[31:0];
                            end
                        end
                        SG_LC:
                        begin
                            load_next = clamp_load(acc_new[7:0]);
                            if (job_reg.frame_type == T_STATE)
                            begin
                                ncp_next = nc_clamp;
                            end
                            else
                            begin
                                cores_next = nc_clamp;
                                if (nc_clamp > cores_reg)
                                begin
                                    zi_next = cores_reg;
                                    st_next = B_ZERO;
                                end
                            end
                        end
                        SG_TEMP:
                        begin
                            temp_next = acc_new[7:0];
                        end
                        SG_RAM:
                        begin
                            tot_next  = ram_tot;
                            used_next = used_c;
                            if (ram_tot == 16'd0)
                            begin
                                pct_next = 7'd0;
                            end
                            else
                            begin
                                div_start = 1'b1;
                                st_next   = B_DIV;
                            end
                        end
                        SG_DISK:
                        begin
                            drd_next = rdp_reg;
                            dwr_next = acc_new[63:10];
                        end
                        SG_UP:
                        begin
                            up_next = acc_new[31:0];
                        end
                        default:
                        begin
                            acc_next = acc_new;
                        end
                    endcase
                end
            end
            B_ZERO:
            begin
                // New cores start at zero load.
                core_we                  = 1'b1;
                core_waddr               = zi_reg[CW-1:0];
                core_wdata               = 7'd0;
                vld_next[zi_reg[CW-1:0]] = 1'b1;
                zi_next                  = zi_reg + 8'd1;
                if ((zi_reg + 8'd1) == cores_reg)
                begin
                    st_next = B_SEGST;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    pct_next = div_q;
                    st_next  = B_SEGST;
                end
            end
            B_OUT:
            begin
                if (result.ready)
                begin
                    frame_done = !job_reg.is_query;
                    st_next    = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= B_IDLE;
            seq_reg   <= 32'd0;
            cores_reg <= (CORES_MAX < 8'd16) ? CORES_MAX : 8'd16;
            load_reg  <= 7'd90;
            temp_reg  <= 8'd79;
            tot_reg   <= 16'd32768;
            used_reg  <= 16'd16384;
            pct_reg   <= 7'd50;
            drd_reg   <= 54'd0;
            dwr_reg   <= 54'd0;
            up_reg    <= 32'd0;
            vld_reg   <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            seq_reg   <= seq_next;
            cores_reg <= cores_next;
            load_reg  <= load_next;
            temp_reg  <= temp_next;
            tot_reg   <= tot_next;
            used_reg  <= used_next;
            pct_reg   <= pct_next;
            drd_reg   <= drd_next;
            dwr_reg   <= dwr_next;
            up_reg    <= up_next;
            vld_reg   <= vld_next;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        seg_reg   <= seg_next;
        k_reg     <= k_next;
        acc_reg   <= acc_next;
        ncp_reg   <= ncp_next;
        rdp_reg   <= rdp_next;
        zi_reg    <= zi_next;
        qv_reg    <= qv_next;
        ostat_reg <= ostat_next;
        ocl_reg   <= ocl_next;
    end

    // Result item.
    assign result.valid           = (st_reg == B_OUT);
    assign result.status          = ostat_reg;
    assign result.overall_load    = load_reg;
    assign result.core_count      = cores_reg[6:0];
    assign result.temperature     = temp_reg;
    assign result.ram_used_mb     = used_reg;
    assign result.ram_total_mb    = tot_reg;
    assign result.ram_percent     = pct_reg;
    assign result.disk_read_kbps  = drd_reg;
    assign result.disk_write_kbps = dwr_reg;
    assign result.uptime_seconds  = up_reg;
    assign result.newest_sequence = seq_reg;
    assign result.core_load       = ocl_reg;
endmodule

// ===== src/telemetry_frame_parser_top.sv =====
// Data bytes that do not end a datagram are taken one per cycle while the job FIFO has room.
// A query goes through the job FIFO, dispatch and a core-load read; a failed frame check ends
// at dispatch or the checksum state. A valid frame is decoded from the payload buffer, each byte
// read then merged, waiting on the RAM percent divider and zeroing each core a CPU frame adds.
// The next byte after a final byte waits until that frame's result is taken.
// Reset (asynchronous, active low) sets control and telemetry state at once; no clearing pass.
module telemetry_frame_parser_top #(
    parameter int MAX_PAYLOAD_BYTES = 128,
    parameter int MAX_CORES = 64
) (
    input logic       clk,
    input logic       rst_n,
    tfp_in_if.sink    datagram,
    tfp_out_if.source result
);
    import tfp_pkg::*;

    localparam int PW = $clog2(MAX_PAYLOAD_BYTES);

    logic          push;
    job_t          push_job;
    logic          fifo_full;
    logic          job_valid;
    job_t          head;
    logic          job_pop;
    logic          frame_done;
    logic          buf_we;
    logic [PW-1:0] buf_waddr;
    logic [7:0]    buf_wdata;
    logic [PW-1:0] buf_raddr;
    logic [7:0]    buf_rdata;

    tfp_front #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .datagram   (datagram),
        .push       (push),
        .push_job   (push_job),
        .fifo_full  (fifo_full),
        .frame_done (frame_done),
        .buf_we     (buf_we),
        .buf_waddr  (buf_waddr),
        .buf_wdata  (buf_wdata)
    );

    tfp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .head      (head)
    );

    tfp_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD_BYTES)) u_payload_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    tfp_back #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES), .MAX_CORES(MAX_CORES)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (head),
        .job_pop    (job_pop),
        .buf_raddr  (buf_raddr),
        .buf_rdata  (buf_rdata),
        .frame_done (frame_done),
        .result     (result)
    );
endmodule

// ===== tb/tb_telemetry_frame_parser_top.sv =====
`timescale 1ns / 1ps

module tb_telemetry_frame_parser_top;
    import tfp_pkg::*;

    localparam int PAYLOAD_MAX = 128;
    localparam int CORE_MAX = 64;
    localparam int STALL_LIMIT = 20000;

    // One expected result of the parser.
    typedef struct {
        logic [3:0]  status;
        logic [6:0]  overall_load;
        logic [6:0]  core_count;
        logic [7:0]  temperature;
        logic [15:0] ram_used_mb;
        logic [15:0] ram_total_mb;
        logic [6:0]  ram_percent;
        logic [53:0] disk_read_kbps;
        logic [53:0] disk_write_kbps;
        logic [31:0] uptime_seconds;
        logic [31:0] newest_sequence;
        logic [6:0]  core_load;
    } telemetry_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   datagrams_sent;
    int   queries_sent;
    int   results_seen;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_idle_pct;

    tfp_in_if  datagram ();
    tfp_out_if result ();

    telemetry_frame_parser_top #(
        .MAX_PAYLOAD_BYTES(PAYLOAD_MAX),
        .MAX_CORES(CORE_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .datagram(datagram.sink),
        .result(result.source)
    );

    // Report one field mismatch and count it.
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("Mismatch in %s at %0t: got %0h, expected %0h", field, $time, got, want);
        error_count++;
    endtask

    // Tracks the parser state and holds the results still due.
    class telemetry_scoreboard;
        logic [10:0] byte_pos;
        logic [15:0] frame_len;
        logic [7:0]  frame_kind;
        logic        header_good;
        logic [7:0]  xor_sum;
        logic [7:0]  payload [PAYLOAD_MAX];
        logic [31:0] newest_seq;
        int          cores;
        logic [6:0]  core_loads [CORE_MAX];
        logic [6:0]  load;
        logic [7:0]  temp;
        logic [15:0] ram_total;
        logic [15:0] ram_used;
        logic [6:0]  ram_pct;
        logic [53:0] disk_rd;
        logic [53:0] disk_wr;
        logic [31:0] uptime;
        telemetry_t  pending [$];

        function new();
            byte_pos = 0;
            frame_len = 0;
            frame_kind = 0;
            header_good = 0;
            xor_sum = 0;
            foreach (payload[i]) payload[i] = 0;
            foreach (core_loads[i]) core_loads[i] = 100;
            newest_seq = 0;
            cores = 16;
            load = 90;
            temp = 79;
            ram_total = 32768;
            ram_used = 16384;
            ram_pct = 50;
            disk_rd = 0;
            disk_wr = 0;
            uptime = 0;
        endfunction

        function logic [7:0] pay(int i);
            return (i < PAYLOAD_MAX) ? payload[i] : 8'd0;
        endfunction

        function logic [63:0] little_endian(int off, int n);
            logic [63:0] v;
            v = 0;
            for (int k = 0; k < n; k++) v |= 64'(pay(off + k)) << (8 * k);
            return v;
        endfunction

        function logic [6:0] clip_load(logic [7:0] v);
            return (v > 100) ? 7'd100 : v[6:0];
        endfunction

        function int clip_cores(logic [7:0] v);
            if (v < 1) return 1;
            if (v > CORE_MAX) return CORE_MAX;
            return v;
        endfunction

        function void resize_cores(int n);
            for (int i = cores; i < n; i++) core_loads[i] = 0;
            cores = n;
        endfunction

        function void fill_cores(int off);
            for (int i = 0; i < cores; i++) core_loads[i] = clip_load(pay(off + i));
        endfunction

        function void apply_ram(int off);
            logic [15:0] tot;
            logic [15:0] used;
            tot = 16'(little_endian(off, 2));
            used = 16'(little_endian(off + 2, 2));
            ram_total = tot;
            ram_used = (used > tot) ? tot : used;
            ram_pct = (tot != 0) ? 7'((32'(ram_used) * 100) / tot) : 7'd0;
        endfunction

        function void apply_disk(int off);
            disk_rd = 54'(little_endian(off, 8) / 1024);
            disk_wr = 54'(little_endian(off + 8, 8) / 1024);
        endfunction

        function logic [3:0] decode_state(int d);
            int c;
            int nc;
            logic [31:0] seq;
            if (d < 4) return ST_PART;
            seq = 32'(little_endian(0, 4));
            if (seq <= newest_seq) return ST_STALE;
            newest_seq = seq;
            c = 4;
            if (d - c < 2) return ST_PART;
            load = clip_load(pay(c));
            nc = clip_cores(pay(c + 1));
            c += 2;
            if (d - c < nc) return ST_PART;
            resize_cores(nc);
            fill_cores(c);
            c += nc;
            if (d - c < 1) return ST_PART;
            temp = pay(c);
            c += 1;
            if (d - c < 4) return ST_PART;
            apply_ram(c);
            c += 4;
            if (d - c < 16) return ST_PART;
            apply_disk(c);
            c += 16;
            if (d - c < 4) return ST_PART;
            uptime = 32'(little_endian(c, 4));
            return ST_OK;
        endfunction

        function logic [3:0] decode_frame();
            int d;
            d = int'(frame_len) - 1;
            case (frame_kind)
                T_STATE: return decode_state(d);
                T_CPU:
                begin
                    if (d < 2) return ST_PART;
                    load = clip_load(pay(0));
                    resize_cores(clip_cores(pay(1)));
                    if (d < 2 + cores) return ST_PART;
                    fill_cores(2);
                    return ST_OK;
                end
                T_TEMP:
                begin
                    if (frame_len < 2) return ST_PART;
                    temp = pay(0);
                    return ST_OK;
                end
                T_RAM:
                begin
                    if (d < 4) return ST_PART;
                    apply_ram(0);
                    return ST_OK;
                end
                T_DISK:
                begin
                    if (d < 16) return ST_PART;
                    apply_disk(0);
                    return ST_OK;
                end
                T_UPTIME:
                begin
                    if (frame_len < 5) return ST_PART;
                    uptime = 32'(little_endian(0, 4));
                    return ST_OK;
                end
                default: return ST_OK;
            endcase
        endfunction

        function logic [3:0] check_frame(int total);
            if (total < 4) return ST_SHORT;
            if (!header_good) return ST_HDR;
            if (frame_len == 0 || frame_len > PAYLOAD_MAX) return ST_LEN;
            if (4 + int'(frame_len) > total) return ST_TRUNC;
            if (xor_sum != pay(int'(frame_len) - 1)) return ST_CHK;
            return decode_frame();
        endfunction

        function void push_result(logic [3:0] st, logic [6:0] cl);
            telemetry_t t;
            t.status = st;
            t.overall_load = load;
            t.core_count = 7'(cores);
            t.temperature = temp;
            t.ram_used_mb = ram_used;
            t.ram_total_mb = ram_total;
            t.ram_percent = ram_pct;
            t.disk_read_kbps = disk_rd;
            t.disk_write_kbps = disk_wr;
            t.uptime_seconds = uptime;
            t.newest_sequence = newest_seq;
            t.core_load = cl;
            pending.push_back(t);
        endfunction

        // Note one accepted input item.
        function void note_input(logic act, logic [7:0] b, logic last, logic [5:0] idx);
            int pos;
            int i;
            logic [3:0] st;
            if (act)
            begin
                push_result(ST_QUERY, (idx < cores) ? core_loads[idx] : 7'd0);
                return;
            end
            pos = byte_pos;
            if (pos == 0) header_good = (b == HDR_MARK);
            else if (pos == 1)
            begin
                frame_len = {8'd0, b};
                xor_sum ^= b;
            end
            else if (pos == 2)
            begin
                frame_len[15:8] = b;
                xor_sum ^= b;
            end
            else if (pos == 3)
            begin
                frame_kind = b;
                xor_sum ^= b;
            end
            else if (pos < POS_LIMIT)
            begin
                i = pos - 4;
                if (i < PAYLOAD_MAX) payload[i] = b;
                if (i + 1 < frame_len) xor_sum ^= b;
            end
            if (pos < POS_LIMIT) byte_pos = 11'(pos + 1);
            if (!last) return;
            st = check_frame(pos + 1);
            byte_pos = 0;
            frame_len = 0;
            frame_kind = 0;
            header_good = 0;
            xor_sum = 0;
            push_result(st, 7'd0);
        endfunction

        // Compare one accepted result with the oldest expectation.
        task check_result(telemetry_t got);
            telemetry_t w;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", got.status, 0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report_mismatch("status", got.status, w.status);
            if (got.overall_load !== w.overall_load)
                report_mismatch("overall_load", got.overall_load, w.overall_load);
            if (got.core_count !== w.core_count)
                report_mismatch("core_count", got.core_count, w.core_count);
            if (got.temperature !== w.temperature)
                report_mismatch("temperature", got.temperature, w.temperature);
            if (got.ram_used_mb !== w.ram_used_mb)
                report_mismatch("ram_used_mb", got.ram_used_mb, w.ram_used_mb);
            if (got.ram_total_mb !== w.ram_total_mb)
                report_mismatch("ram_total_mb", got.ram_total_mb, w.ram_total_mb);
            if (got.ram_percent !== w.ram_percent)
                report_mismatch("ram_percent", got.ram_percent, w.ram_percent);
            if (got.disk_read_kbps !== w.disk_read_kbps)
                report_mismatch("disk_read_kbps", got.disk_read_kbps, w.disk_read_kbps);
            if (got.disk_write_kbps !== w.disk_write_kbps)
                report_mismatch("disk_write_kbps", got.disk_write_kbps, w.disk_write_kbps);
            if (got.uptime_seconds !== w.uptime_seconds)
                report_mismatch("uptime_seconds", got.uptime_seconds, w.uptime_seconds);
            if (got.newest_sequence !== w.newest_sequence)
                report_mismatch("newest_sequence", got.newest_sequence, w.newest_sequence);
            if (got.core_load !== w.core_load)
                report_mismatch("core_load", got.core_load, w.core_load);
        endtask
    endclass

    telemetry_scoreboard board;

    // Clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver side: random back-pressure, sample on accept, watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        telemetry_t got;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.status = result.status;
                got.overall_load = result.overall_load;
                got.core_count = result.core_count;
                got.temperature = result.temperature;
                got.ram_used_mb = result.ram_used_mb;
                got.ram_total_mb = result.ram_total_mb;
                got.ram_percent = result.ram_percent;
                got.disk_read_kbps = result.disk_read_kbps;
                got.disk_write_kbps = result.disk_write_kbps;
                got.uptime_seconds = result.uptime_seconds;
                got.newest_sequence = result.newest_sequence;
                got.core_load = result.core_load;
                board.check_result(got);
                results_seen++;
            end
            if ((result.valid && result.ready) || (datagram.valid && datagram.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
            result.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send one input item and wait until it is taken.
    task automatic send_item(input logic act, input logic [7:0] b, input logic last,
                             input logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            datagram.valid <= 1'b0;
            @(posedge clk);
        end
        datagram.valid <= 1'b1;
        datagram.action <= act;
        datagram.data_byte <= b;
        datagram.end_of_datagram <= last;
        datagram.core_index <= idx;
        do @(posedge clk); while (!datagram.ready);
        board.note_input(act, b, last, idx);
        if (act) queries_sent++;
        else if (last) datagrams_sent++;
    endtask

    // Send a byte string as one datagram, with optional queries mixed in.
    task automatic send_datagram(input logic [7:0] bytes [$], input int query_pct);
        for (int i = 0; i < bytes.size(); i++)
        begin
            if ($urandom_range(99) < query_pct)
                send_item(1'b1, 8'($urandom), 1'($urandom), 6'($urandom));
            send_item(1'b0, bytes[i], i == bytes.size() - 1, 6'($urandom));
        end
    endtask

    // Build a framed datagram: header, length, type, payload, checksum.
    function automatic void build_frame(output logic [7:0] bytes [$], input logic [7:0] kind,
                                        input logic [7:0] body [$]);
        logic [7:0]  chk;
        logic [15:0] len;
        len = 16'(body.size() + 1);
        chk = len[7:0] ^ len[15:8] ^ kind;
        foreach (body[i]) chk ^= body[i];
        bytes = {HDR_MARK, len[7:0], len[15:8], kind};
        foreach (body[i]) bytes.push_back(body[i]);
        bytes.push_back(chk);
    endfunction

    function automatic logic [7:0] rand_load();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(100));
    endfunction

    // Random payload body suited to one frame type.
    function automatic void make_body(output logic [7:0] body [$], input logic [7:0] kind,
                                      inout logic [31:0] seq);
        int n;
        body = {};
        case (kind)
            T_CPU:
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 20);
                body = {rand_load(), 8'(n)};
                for (int i = 0; i < n && body.size() < PAYLOAD_MAX - 1; i++)
                    body.push_back(rand_load());
            end
            T_STATE:
            begin
                seq = ($urandom_range(7) == 0) ? seq - $urandom_range(3) : seq + $urandom_range(1, 9);
                n = $urandom_range(1, 24);
                body = {seq[7:0], seq[15:8], seq[23:16], seq[31:24], rand_load(), 8'(n)};
                for (int i = 0; i < n; i++) body.push_back(rand_load());
                for (int i = 0; i < 25; i++) body.push_back(8'($urandom));
                if ($urandom_range(1) == 0) body[body.size() - 21] = body[body.size() - 23];
            end
            T_RAM:
            begin
                for (int i = 0; i < 4; i++) body.push_back(8'($urandom));
                if ($urandom_range(3) == 0) {body[3], body[2]} = {body[1], body[0]} >> 1;
            end
            T_DISK: for (int i = 0; i < 16; i++) body.push_back(8'($urandom));
            T_UPTIME: for (int i = 0; i < 4; i++) body.push_back(8'($urandom));
            T_TEMP: body.push_back(8'($urandom));
            default: for (int i = $urandom_range(3); i > 0; i--) body.push_back(8'($urandom));
        endcase
        // Sometimes cut the payload short to exercise partial commits.
        if ($urandom_range(5) == 0 && body.size() > 0)
            body = body[0:$urandom_range(body.size() - 1)];
        if (body.size() > PAYLOAD_MAX - 1) body = body[0:PAYLOAD_MAX - 2];
    endfunction

    // One random datagram: mostly well-formed frames, some broken ones.
    task automatic send_random_datagram(inout logic [31:0] seq);
        logic [7:0] body [$];
        logic [7:0] bytes [$];
        logic [7:0] kind;
        int pick;
        pick = $urandom_range(6);
        kind = ($urandom_range(15) == 0) ? 8'($urandom) : 8'(pick);
        make_body(body, kind, seq);
        build_frame(bytes, kind, body);
        case ($urandom_range(19))
            0: bytes[0] = 8'($urandom);
            1: bytes[bytes.size() - 1] ^= 8'(1 << $urandom_range(7));
            2: bytes = bytes[0:$urandom_range(bytes.size() - 1)];
            3: {bytes[2], bytes[1]} = 16'($urandom);
            4: for (int i = $urandom_range(1, 5); i > 0; i--) bytes.push_back(8'($urandom));
            default: ;
        endcase
        send_datagram(bytes, 8);
    endtask

    // Wait until every expected result has been taken.
    task automatic drain();
        datagram.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] body [$];
        logic [7:0] bytes [$];
        logic [31:0] seq;
        board = new();
        error_count = 0;
        datagrams_sent = 0;
        queries_sent = 0;
        results_seen = 0;
        send_idle_pct = 15;
        recv_idle_pct = 81;
        rst_n = 1'b0;
        datagram.valid = 1'b0;
        datagram.action = 1'b0;
        datagram.data_byte = 8'd0;
        datagram.end_of_datagram = 1'b0;
        datagram.core_index = 6'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, short, bad header, bad length, truncation, checksum.
        send_item(1'b1, 8'h00, 1'b1, 6'd0);
        send_item(1'b1, 8'hFF, 1'b0, 6'd63);
        send_datagram({8'hFA, 8'h01, 8'h00}, 0);
        send_datagram({8'h00, 8'h02, 8'h00, T_TEMP, 8'h33, 8'h31}, 0);
        send_datagram({HDR_MARK, 8'h00, 8'h00, T_TEMP, 8'h00}, 0);
        send_datagram({HDR_MARK, 8'hFF, 8'hFF, T_TEMP, 8'h00}, 0);
        send_datagram({HDR_MARK, 8'h05, 8'h00, T_UPTIME, 8'h01}, 0);
        send_datagram({HDR_MARK, 8'h02, 8'h00, T_TEMP, 8'hFF, 8'h00}, 0);
        // Temperature with trailing bytes, then a frame with no data.
        send_datagram({HDR_MARK, 8'h02, 8'h00, T_TEMP, 8'hFF, 8'hFD, 8'hAA, 8'h55}, 0);
        send_datagram({HDR_MARK, 8'h01, 8'h00, T_TEMP, 8'h01}, 0);
        // CPU frame that grows the core count to the maximum, loads clamped.
        body = {8'hFF, 8'hFF};
        for (int i = 0; i < CORE_MAX; i++) body.push_back(8'(i * 4));
        build_frame(bytes, T_CPU, body);
        send_datagram(bytes, 0);
        send_item(1'b1, 8'h00, 1'b0, 6'd63);
        // CPU frame with zero cores, short of its loads.
        build_frame(bytes, T_CPU, {8'd7, 8'd0});
        send_datagram(bytes, 0);
        // RAM with used above total and with total zero.
        build_frame(bytes, T_RAM, {8'h10, 8'h00, 8'hFF, 8'hFF});
        send_datagram(bytes, 0);
        build_frame(bytes, T_RAM, {8'h00, 8'h00, 8'h05, 8'h00});
        send_datagram(bytes, 0);
        body = {};
        for (int i = 0; i < 16; i++) body.push_back(8'hFF);
        build_frame(bytes, T_DISK, body);
        send_datagram(bytes, 0);
        build_frame(bytes, T_UPTIME, {8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_datagram(bytes, 0);
        build_frame(bytes, 8'hFF, {8'h01});
        send_datagram(bytes, 0);
        // A full-length STATE frame, then the same sequence again (stale).
        body = {8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'd55, 8'd3, 8'd10, 8'd20, 8'd200, 8'd80,
                8'h00, 8'h80, 8'h00, 8'h40};
        for (int i = 0; i < 20; i++) body.push_back(8'($urandom));
        while (body.size() < PAYLOAD_MAX - 1) body.push_back(8'hA5);
        build_frame(bytes, T_STATE, body);
        send_datagram(bytes, 0);
        send_datagram(bytes, 0);
        // Long datagram that runs well past the payload buffer.
        bytes = {};
        for (int i = 0; i < 300; i++) bytes.push_back(8'($urandom));
        bytes[0] = HDR_MARK;
        send_datagram(bytes, 0);
        drain();

        // Random part in three idling phases.
        seq = 32'h7FFF_FFFF;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 15 : 0;
            for (int n = 0; n < 20; n++)
            begin
                seq = (ph == 2 && n == 0) ? 32'hFFFF_FFF0 : seq;
                send_random_datagram(seq);
            end
            drain();
        end

        // Final wait for stray results, then verdict.
        repeat (300) @(posedge clk);
        $display("Run covered %0d datagrams and %0d core queries, %0d results checked.",
                 datagrams_sent, queries_sent, results_seen);
        $display("All frame types, every check failure, partial and stale frames were exercised.");
        if (error_count == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
src/tfp_pkg.sv
src/tfp_ifs.sv
src/tfp_ram.sv
src/tfp_fifo.sv
src/tfp_pct_div.sv
src/tfp_front.sv
src/tfp_back.sv
src/telemetry_frame_parser_top.sv
tb/tb_telemetry_frame_parser_top.sv
